// ----- rtl/core/dijkstra_shortest_path_unit_assert.svh -----
// Assertion macros for the shortest path unit
`ifndef DIJKSTRA_SHORTEST_PATH_UNIT_ASSERT_SVH
`define DIJKSTRA_SHORTEST_PATH_UNIT_ASSERT_SVH

// Implication checked on every rising edge, disabled during reset.
`define DSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent, disabled during reset.
`define DSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/dsp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsp_pkg
// Shared constants and types for the shortest path unit.
// ----------------------------------------------------------------------------
package dsp_pkg;
    localparam int DSP_MAX_NODES   = 16;
    localparam int DSP_WEIGHT_BITS = 16;
    localparam int DIST_BITS       = 20;
    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_INIT   = 8'b0000_0010,
        ST_RELAX  = 8'b0000_0100,
        ST_SELECT = 8'b0000_1000,
        ST_TRACE  = 8'b0001_0000,
        ST_EMIT   = 8'b0010_0000,
        ST_ADD    = 8'b0100_0000,
        ST_CLEAR  = 8'b1000_0000
    } t_state;
endpackage

// ----- rtl/core/dijkstra_shortest_path_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dijkstra_shortest_path_unit
// Dense single-pair shortest path engine over an adjacency matrix memory.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall): one beat per command. Add edge reads and
// writes the matrix. Clear sweeps the MAX_NODES*MAX_NODES presence bits, one
// per cycle. A query takes a setup step (ST_INIT) and up to N-1 rounds; each
// round scans the N matrix entries of the current node through the single
// memory read port and one add/compare unit, then scans N candidates with one
// compare unit. Trace back visits up to N nodes and output up to N beats.
// The path is traced back through the predecessor table (one node per
// cycle) and sent on the output channel (o_valid / i_stall), one beat per
// path node from start to end, last set on the final beat. A not-found query
// gives one beat with found low.
// The output register holds its beat while i_stall is high; the sequencer
// waits. o_stall is high whenever the unit is busy.
// Reset (i_rst_n low, synchronous) sets node_count to 16 and starts a clear
// pass over the presence bits with o_stall high. The user writes node_count
// with i_cfg_we only while the unit is idle; the unit does not enforce it.
// ----------------------------------------------------------------------------
module dijkstra_shortest_path_unit
    import dsp_pkg::*;
#(
    parameter int MAX_NODES   = DSP_MAX_NODES,
    parameter int WEIGHT_BITS = DSP_WEIGHT_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [4:0]             i_cfg_wdata,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [1:0]             i_cmd,
    input  logic [3:0]             i_node_a,
    input  logic [3:0]             i_node_b,
    input  logic [15:0]            i_weight,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_found,
    output logic [3:0]             o_path_node,
    output logic [3:0]             o_hop_count,
    output logic [DIST_BITS-1:0]   o_total_distance,
    output logic                   o_last
);
    localparam int NB = $clog2(MAX_NODES);
    localparam int AB = 2 * NB;
    localparam int ND = MAX_NODES * MAX_NODES;
    localparam int CB = $clog2(MAX_NODES + 1);
    localparam int WB = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;

    t_state r_state;
    logic [4:0] r_cfg;

    logic [WEIGHT_BITS-1:0] r_wmem [ND];
    logic [ND-1:0]          r_present;
    logic [WEIGHT_BITS-1:0] r_rd_w;
    logic                   r_rd_p;

    logic [DIST_BITS-1:0] r_dist [MAX_NODES];
    logic [NB-1:0]        r_pred [MAX_NODES];
    logic [MAX_NODES-1:0] r_reach, r_settled;

    logic [NB-1:0] r_a, r_b, r_cur, r_v, r_pick;
    logic [WEIGHT_BITS-1:0] r_w;
    logic          r_have, r_rd_ok;
    logic [CB-1:0] r_n, r_iter;
    logic [AB:0]   r_clr;

    logic [NB-1:0] r_path [MAX_NODES];
    logic [CB-1:0] r_len, r_idx;
    logic          r_emit_found;

    logic [CB-1:0] w_n;
    always_comb begin
        if (r_cfg == 5'd0) w_n = CB'(1);
        else if (32'(r_cfg) > MAX_NODES) w_n = CB'(MAX_NODES);
        else w_n = CB'(r_cfg);
    end

    logic w_acc;
    assign o_stall = (r_state != ST_IDLE);
    assign w_acc   = i_valid && (r_state == ST_IDLE);

    logic [AB-1:0] w_rd_addr;
    always_comb begin
        if (r_state == ST_IDLE) w_rd_addr = {NB'(i_node_a), NB'(i_node_b)};
        else w_rd_addr = {r_cur, r_v};
    end

    always_ff @(posedge i_clk) begin
        r_rd_w <= r_wmem[w_rd_addr];
        r_rd_p <= r_present[w_rd_addr];
    end

    // relax arithmetic
    logic [DIST_BITS:0] w_sum;
    logic [DIST_BITS-1:0] w_sat;
    logic [NB-1:0] w_vd;
    logic w_vd_ok;
    assign w_sum = {1'b0, r_dist[r_cur]} + (DIST_BITS+1)'(r_rd_w);
    assign w_sat = w_sum[DIST_BITS] ? DIST_MAX : w_sum[DIST_BITS-1:0];
    assign w_vd  = r_v - NB'(1);
    assign w_vd_ok = r_rd_ok;

    logic w_out_free;
    assign w_out_free = !o_valid || !i_stall;

    logic w_in_range;
    assign w_in_range = (CB'(i_node_a) < w_n) && (CB'(i_node_b) < w_n)
                        && (32'(i_node_a) < MAX_NODES) && (32'(i_node_b) < MAX_NODES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_cfg     <= 5'd16;
            o_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) r_cfg <= i_cfg_wdata;
            if (o_valid && !i_stall) o_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    r_a <= NB'(i_node_a);
                    r_b <= NB'(i_node_b);
                    r_w <= WEIGHT_BITS'(i_weight[WB-1:0]);
                    r_n <= w_n;
                    if (w_acc) begin
                        case (i_cmd)
                            CMD_ADD: if (w_in_range) r_state <= ST_ADD;
                            CMD_CLEAR: begin
                                r_clr   <= '0;
                                r_state <= ST_CLEAR;
                            end
                            CMD_QUERY: begin
                                if (!w_in_range) begin
                                    r_emit_found <= 1'b0;
                                    r_len   <= CB'(1);
                                    r_idx   <= '0;
                                    r_state <= ST_EMIT;
                                end else begin
                                    r_v     <= '0;
                                    r_state <= ST_INIT;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_ADD: begin
                    if (!r_rd_p || r_w < r_rd_w) begin
                        r_wmem[{r_a, r_b}]    <= r_w;
                        r_present[{r_a, r_b}] <= 1'b1;
                    end
                    r_state <= ST_IDLE;
                end
                ST_CLEAR: begin
                    r_present[r_clr[AB-1:0]] <= 1'b0;
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (AB+1)'(ND - 1)) r_state <= ST_IDLE;
                end
                ST_INIT: begin
                    r_reach   <= '0;
                    r_settled <= '0;
                    r_reach[r_a]   <= 1'b1;
                    r_settled[r_a] <= 1'b1;
                    r_dist[r_a] <= '0;
                    r_cur  <= r_a;
                    r_iter <= '0;
                    r_v    <= '0;
                    r_rd_ok <= 1'b0;
                    r_state <= ST_RELAX;
                    if (r_a == r_b) begin
                        r_path[0] <= r_a;
                        r_len <= CB'(1);
                        r_idx <= '0;
                        r_emit_found <= 1'b1;
                        r_state <= ST_EMIT;
                    end
                end
                ST_RELAX: begin
                    // read of r_v issued this cycle; data for r_v-1 is here
                    if (w_vd_ok && r_rd_p) begin
                        if (!r_reach[w_vd] || w_sat < r_dist[w_vd]) begin
                            r_dist[w_vd]  <= w_sat;
                            r_reach[w_vd] <= 1'b1;
                            r_pred[w_vd]  <= r_cur;
                        end
                    end
                    if (CB'(r_v) == r_n - 1'b1 && r_rd_ok && CB'(w_vd) == r_n - CB'(2)
                        || !r_rd_ok && r_n == CB'(1)) begin
                        r_rd_ok <= 1'b1;
                    end
                    if (r_rd_ok && CB'(w_vd) == r_n - 1'b1) begin
                        r_v <= '0;
                        r_have <= 1'b0;
                        r_state <= ST_SELECT;
                    end else begin
                        r_rd_ok <= 1'b1;
                        if (CB'(r_v) != r_n - 1'b1 || !r_rd_ok) r_v <= r_v + 1'b1;
                        if (CB'(r_v) == r_n - 1'b1) r_v <= r_v + 1'b1;
                    end
                end
                ST_SELECT: begin
                    if (!r_settled[r_v] && r_reach[r_v]
                        && (!r_have || r_dist[r_v] < r_dist[r_pick])) begin
                        r_pick <= r_v;
                        r_have <= 1'b1;
                    end
                    r_v <= r_v + 1'b1;
                    if (CB'(r_v) == r_n - 1'b1) begin
                        r_v <= r_b;
                        r_len <= '0;
                        if (!r_settled[r_v] && r_reach[r_v]
                            && (!r_have || r_dist[r_v] < r_dist[r_pick])) begin
                            r_cur <= r_v;
                            r_settled[r_v] <= 1'b1;
                        end else if (r_have) begin
                            r_cur <= r_pick;
                            r_settled[r_pick] <= 1'b1;
                        end
                        if (!r_have && !(!r_settled[r_v] && r_reach[r_v])) begin
                            r_emit_found <= 1'b0;
                            r_len <= CB'(1);
                            r_idx <= '0;
                            r_state <= ST_EMIT;
                        end else if (((!r_settled[r_v] && r_reach[r_v]
                            && (!r_have || r_dist[r_v] < r_dist[r_pick])) ? r_v : r_pick)
                            == r_b) begin
                            r_state <= ST_TRACE;
                        end else if (r_iter + 1'b1 >= r_n - 1'b1) begin
                            r_emit_found <= 1'b0;
                            r_len <= CB'(1);
                            r_idx <= '0;
                            r_state <= ST_EMIT;
                        end else begin
                            r_iter <= r_iter + 1'b1;
                            r_v <= '0;
                            r_rd_ok <= 1'b0;
                            r_state <= ST_RELAX;
                        end
                    end
                end
                ST_TRACE: begin
                    // collects end..start in reverse
                    r_path[r_len[NB-1:0]] <= r_v;
                    r_len <= r_len + 1'b1;
                    r_v <= r_pred[r_v];
                    if (r_v == r_a || r_len + 1'b1 == r_n) begin
                        r_emit_found <= 1'b1;
                        r_idx <= '0;
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (w_out_free) begin
                        o_valid <= 1'b1;
                        o_found <= r_emit_found;
                        o_path_node <= r_emit_found ?
                            4'(r_path[NB'(r_len - 1'b1 - r_idx)]) : 4'd0;
                        o_hop_count <= r_emit_found ? 4'(r_len - 1'b1) : 4'd0;
                        o_total_distance <= r_emit_found ? r_dist[r_b] : '0;
                        o_last <= (r_idx + 1'b1 == r_len);
                        r_idx <= r_idx + 1'b1;
                        if (r_idx + 1'b1 == r_len) r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule

// ----- rtl/core/dsp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsp_checker
// Port-level checks of the shortest path unit.
// ----------------------------------------------------------------------------
`include "dijkstra_shortest_path_unit_assert.svh"
module dsp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_found,
    input logic [3:0] o_hop_count,
    input logic       o_last
);
    `DSP_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_last))
    `DSP_ASSERT_IMP(a_nf_last, i_clk, i_rst_n, o_valid && !o_found, o_last && o_hop_count == 4'd0)
    `DSP_ASSERT_IMP(a_busy_out, i_clk, i_rst_n, o_valid && !o_last, o_stall)
endmodule

bind dijkstra_shortest_path_unit dsp_checker u_dsp_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_stall(o_stall), .o_valid(o_valid),
    .i_stall(i_stall), .o_found(o_found), .o_hop_count(o_hop_count), .o_last(o_last)
);

// ----- bench/dijkstra_shortest_path_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dijkstra_shortest_path_checker
// Watches the command and path channels of the shortest path unit, keeps its
// own copy of the graph and node count, computes the expected path beats for
// each query and compares every output beat field by field.
// ----------------------------------------------------------------------------
module dijkstra_shortest_path_checker
    import dsp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [4:0]           i_cfg_wdata,
    input  logic                 i_valid,
    input  logic                 i_dut_stall,
    input  logic [1:0]           i_cmd,
    input  logic [3:0]           i_node_a,
    input  logic [3:0]           i_node_b,
    input  logic [15:0]          i_weight,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic                 i_found,
    input  logic [3:0]           i_path_node,
    input  logic [3:0]           i_hop_count,
    input  logic [DIST_BITS-1:0] i_total_distance,
    input  logic                 i_last,
    output int                   o_errors,
    output int                   o_pending
);
    typedef struct packed {
        logic                 found;
        logic [3:0]           node;
        logic [3:0]           hops;
        logic [DIST_BITS-1:0] tot;
        logic                 last;
    } t_beat;

    t_beat      path_q[$];
    logic [15:0] wt[16][16];
    logic       present[16][16];
    logic [4:0] node_cnt;

    function automatic int active_n();
        if (node_cnt == 0) return 1;
        if (node_cnt > 16) return 16;
        return node_cnt;
    endfunction

    function automatic t_beat mk(logic f, logic [3:0] nd, logic [3:0] h,
                                 logic [DIST_BITS-1:0] d, logic l);
        t_beat b;
        b.found = f; b.node = nd; b.hops = h; b.tot = d; b.last = l;
        return b;
    endfunction

    task automatic predict_path(int s, int e);
        int n;
        logic [DIST_BITS-1:0] best_d[16];
        logic reach[16], done[16];
        int pred[16], path[16];
        int cur, pick, len, v;
        logic have, hit;
        longint sum;
        n = active_n();
        hit = 0;
        if (s >= n || e >= n) begin
            path_q.push_back(mk(0, 0, 0, 0, 1));
            return;
        end
        for (int i = 0; i < 16; i++) begin
            best_d[i] = 0; reach[i] = 0; done[i] = 0; pred[i] = 0;
        end
        reach[s] = 1; done[s] = 1; cur = s;
        for (int it = 0; it < n; it++) begin
            if (cur == e) begin
                hit = 1;
                break;
            end
            for (int i = 0; i < n; i++) begin
                if (!present[cur][i]) continue;
                sum = longint'(best_d[cur]) + wt[cur][i];
                if (sum > DIST_MAX) sum = DIST_MAX;
                if (!reach[i] || sum < best_d[i]) begin
                    best_d[i] = sum[DIST_BITS-1:0]; reach[i] = 1; pred[i] = cur;
                end
            end
            have = 0; pick = 0;
            for (int i = 0; i < n; i++) begin
                if (done[i] || !reach[i]) continue;
                if (!have || best_d[i] < best_d[pick]) begin
                    pick = i; have = 1;
                end
            end
            if (!have) break;
            done[pick] = 1; cur = pick;
        end
        if (!hit) begin
            path_q.push_back(mk(0, 0, 0, 0, 1));
            return;
        end
        len = 0; v = e; path[len++] = v;
        while (v != s && len < n) begin
            v = pred[v]; path[len++] = v;
        end
        for (int i = 0; i < len; i++)
            path_q.push_back(mk(1'b1, 4'(path[len-1-i]), 4'(len-1), best_d[e],
                                i + 1 == len));
    endtask

    assign o_pending = path_q.size();

    always @(posedge i_clk) begin
        t_beat got, want;
        if (!i_rst_n) begin
            node_cnt <= 5'd16;
            o_errors <= 0;
            path_q.delete();
            for (int i = 0; i < 16; i++)
                for (int j = 0; j < 16; j++) present[i][j] = 0;
        end else begin
            if (i_cfg_we) node_cnt <= i_cfg_wdata;
            if (i_out_valid && !i_out_stall) begin
                got = mk(i_found, i_path_node, i_hop_count, i_total_distance, i_last);
                if (path_q.size() == 0) begin
                    $display("%0t: expected no beat, got %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = path_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: expected f=%0d n=%0d h=%0d d=%0d l=%0d, got f=%0d n=%0d h=%0d d=%0d l=%0d",
                                 $time, want.found, want.node, want.hops, want.tot,
                                 want.last, got.found, got.node, got.hops, got.tot,
                                 got.last);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_valid && !i_dut_stall) begin
                case (i_cmd)
                    CMD_ADD: begin
                        if (i_node_a < active_n() && i_node_b < active_n()) begin
                            if (!present[i_node_a][i_node_b]
                                || i_weight < wt[i_node_a][i_node_b]) begin
                                wt[i_node_a][i_node_b] = i_weight;
                                present[i_node_a][i_node_b] = 1;
                            end
                        end
                    end
                    CMD_QUERY: predict_path(i_node_a, i_node_b);
                    CMD_CLEAR: begin
                        for (int i = 0; i < 16; i++)
                            for (int j = 0; j < 16; j++) present[i][j] = 0;
                    end
                    default: ;
                endcase
            end
        end
    end
endmodule

// ----- bench/dijkstra_shortest_path_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dijkstra_shortest_path_unit_tb
// Loads random and hand-built graphs, runs path queries under several node
// counts with random gaps and output stalls; the checker compares the paths.
// ----------------------------------------------------------------------------
module dijkstra_shortest_path_unit_tb;
    import dsp_pkg::*;

    logic                 i_clk, i_rst_n;
    logic                 cfg_we;
    logic [4:0]           cfg_wdata;
    logic                 in_valid, in_stall;
    logic [1:0]           cmd;
    logic [3:0]           node_a, node_b;
    logic [15:0]          weight;
    logic                 out_valid, out_stall;
    logic                 found, last;
    logic [3:0]           path_node, hop_count;
    logic [DIST_BITS-1:0] total_distance;
    int                   errors, pending;
    logic [4:0]           cur_n;
    int                   in_gap = 0;

    dijkstra_shortest_path_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_cmd(cmd), .i_node_a(node_a), .i_node_b(node_b), .i_weight(weight),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_found(found), .o_path_node(path_node), .o_hop_count(hop_count),
        .o_total_distance(total_distance), .o_last(last)
    );

    dijkstra_shortest_path_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_valid(in_valid), .i_dut_stall(in_stall),
        .i_cmd(cmd), .i_node_a(node_a), .i_node_b(node_b), .i_weight(weight),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_found(found), .i_path_node(path_node), .i_hop_count(hop_count),
        .i_total_distance(total_distance), .i_last(last),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #60000000;
        $display("Mismatches found");
        $finish;
    end

    // receiver stalls for a random hold before each beat, often none
    initial begin
        int hold;
        out_stall = 0;
        forever begin
            hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            if (hold != 0) begin
                out_stall <= 1;
                repeat (hold) @(posedge i_clk);
            end
            out_stall <= 0;
            do @(posedge i_clk); while (!out_valid);
        end
    end

    task automatic send_beat(logic [1:0] c, logic [3:0] a, logic [3:0] b,
                             logic [15:0] w);
        repeat (in_gap) @(posedge i_clk);
        in_valid <= 1; cmd <= c; node_a <= a; node_b <= b; weight <= w;
        do @(posedge i_clk); while (in_stall);
        in_gap = $urandom_range(0, 5);
        if (in_gap != 0) in_valid <= 0;
    endtask

    task automatic drain();
        if (in_gap == 0) in_valid <= 0;
        in_gap = $urandom_range(0, 5);
        repeat (2) @(posedge i_clk);
        while (pending != 0 || in_stall) @(posedge i_clk);
    endtask

    task automatic set_nodes(logic [4:0] v);
        drain();
        cfg_we <= 1; cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we <= 0;
        cur_n = v;
    endtask

    function automatic logic [3:0] pick_node();
        int lim;
        lim = (cur_n == 0) ? 1 : (cur_n > 16 ? 16 : cur_n);
        if ($urandom_range(0, 9) == 0) return 4'($urandom_range(0, 15));
        return 4'($urandom_range(0, lim - 1));
    endfunction

    task automatic random_phase(int count);
        int k;
        k = 0;
        while (k < count) begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 60)
                send_beat(CMD_ADD, pick_node(), pick_node(),
                          ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 300)));
            else if (r < 94)
                send_beat(CMD_QUERY, pick_node(), pick_node(), 16'($urandom));
            else if (r < 97)
                send_beat(CMD_CLEAR, pick_node(), pick_node(), 16'($urandom));
            else
                send_beat(2'd3, pick_node(), pick_node(), 16'($urandom));
            k++;
        end
    endtask

    initial begin
        i_rst_n = 0; cfg_we = 0; cfg_wdata = 0; in_valid = 0;
        cmd = 0; node_a = 0; node_b = 0; weight = 0; cur_n = 16;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: chain of maximum weights, ties, self loop, repeats, misses
        send_beat(CMD_QUERY, 0, 0, 0);
        send_beat(CMD_QUERY, 0, 15, 0);
        for (int i = 0; i < 15; i++) send_beat(CMD_ADD, 4'(i), 4'(i + 1), 16'hFFFF);
        send_beat(CMD_ADD, 3, 3, 0);
        send_beat(CMD_ADD, 0, 1, 16'hFFFF);
        send_beat(CMD_QUERY, 0, 15, 0);
        send_beat(CMD_ADD, 0, 2, 0);
        send_beat(CMD_ADD, 0, 2, 5);
        send_beat(CMD_QUERY, 15, 0, 0);
        send_beat(CMD_QUERY, 0, 2, 0);
        send_beat(2'd3, 1, 2, 3);
        drain();
        send_beat(CMD_CLEAR, 15, 15, 16'hFFFF);
        send_beat(CMD_QUERY, 0, 1, 0);

        set_nodes(0);
        send_beat(CMD_ADD, 0, 1, 1);
        send_beat(CMD_QUERY, 0, 0, 0);
        send_beat(CMD_QUERY, 0, 1, 0);
        random_phase(20);

        set_nodes(4);
        random_phase(110);
        set_nodes(31);
        random_phase(100);
        set_nodes(16);
        random_phase(60);
        set_nodes(8);
        send_beat(CMD_CLEAR, 0, 0, 0);
        random_phase(100);
        set_nodes(1);
        random_phase(15);

        drain();
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/dsp_pkg.sv
rtl/core/dijkstra_shortest_path_unit.sv
rtl/core/dsp_checker.sv
bench/dijkstra_shortest_path_checker.sv
bench/dijkstra_shortest_path_unit_tb.sv
